>>> hdl/jsr_pkg.sv
// Shared types and constants of the Jacobi five-point relaxation unit.
// No dependencies; every other file of the unit imports it.
package jsr_pkg;

  localparam int VAL_W       = 32;
  localparam int ROW_W       = 12;
  localparam int COL_W       = 10;
  localparam int RES_W       = 63;
  localparam int SQ_W        = 2 * VAL_W;
  localparam int ROWS_CFG_W  = 13;
  localparam int COLS_CFG_W  = 11;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_ROWS    = 4096;
  localparam int MAX_COLUMNS = 1024;
  localparam int MIN_SIZE    = 3;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(1024);
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(1024);
  localparam logic [RES_W-1:0]      RES_MAX    = {RES_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS    = 1'b0,
    REG_GRID_COLUMNS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             first;
    logic             last;
  } jsr_tag_t;

endpackage

>>> hdl/jsr_line_buf.sv
// Two line buffers of the relaxation unit: previous row and the row before it.
// Synchronous read, registered data. Depends on jsr_pkg.
module jsr_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  input  logic [jsr_pkg::VAL_W-1:0] mid_wdata,
  input  logic                     up_wr_en,
  input  logic [AW-1:0]            up_waddr,
  input  logic [jsr_pkg::VAL_W-1:0] up_wdata,
  output logic [jsr_pkg::VAL_W-1:0] mid_q,
  output logic [jsr_pkg::VAL_W-1:0] up_q
);
  import jsr_pkg::*;

  logic [VAL_W-1:0] mid_mem [DEPTH];
  logic [VAL_W-1:0] up_mem  [DEPTH];
  logic [VAL_W-1:0] mid_q_r;
  logic [VAL_W-1:0] up_q_r;

  // read old contents, then replace with the incoming row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_q_r          <= mid_mem[rd_addr];
      mid_mem[rd_addr] <= mid_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q_r <= up_mem[rd_addr];
    end
    if (up_wr_en) begin
      up_mem[up_waddr] <= up_wdata;
    end
  end

  assign mid_q = mid_q_r;
  assign up_q  = up_q_r;

endmodule

>>> hdl/jsr_stencil.sv
// Five-point window and quarter-sum datapath with the change magnitude.
// Depends on jsr_pkg.
module jsr_stencil (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [jsr_pkg::VAL_W-1:0] cur_val,
  input  logic [jsr_pkg::VAL_W-1:0] mid_q,
  input  logic [jsr_pkg::VAL_W-1:0] up_q,
  output logic [jsr_pkg::VAL_W-1:0] new_value,
  output logic [jsr_pkg::VAL_W-1:0] mag
);
  import jsr_pkg::*;

  logic [VAL_W-1:0] win1_r;
  logic [VAL_W-1:0] win2_r;
  logic [VAL_W-1:0] up_prev_r;
  logic [VAL_W-1:0] cell_prev_r;
  logic [VAL_W+1:0] sum;
  logic [VAL_W:0]   diff;
  logic [VAL_W:0]   diff_neg;

  // left = win1, center = win2, right = mid_q, top = up_prev, bottom = cell_prev
  always_comb begin
    sum = {{2{win1_r[VAL_W-1]}}, win1_r} + {{2{mid_q[VAL_W-1]}}, mid_q}
        + {{2{up_prev_r[VAL_W-1]}}, up_prev_r}
        + {{2{cell_prev_r[VAL_W-1]}}, cell_prev_r};
    new_value = sum[VAL_W+1:2];
    diff      = {new_value[VAL_W-1], new_value} - {win2_r[VAL_W-1], win2_r};
    diff_neg  = -diff;
    mag       = diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win1_r      <= win2_r;
      win2_r      <= mid_q;
      up_prev_r   <= up_q;
      cell_prev_r <= cur_val;
    end
  end

endmodule

>>> hdl/jsr_residual.sv
// Squared-change multiplier stage and saturating residual accumulator.
// Depends on jsr_pkg.
module jsr_residual (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      sq_load,
  input  logic [jsr_pkg::VAL_W-1:0] mag,
  input  logic                      acc_step,
  input  logic                      first,
  input  logic                      emit,
  output logic [jsr_pkg::RES_W-1:0] acc_value
);
  import jsr_pkg::*;

  logic [SQ_W-1:0]  sq_r;
  logic [SQ_W-1:0]  sq_nxt;
  logic [RES_W-1:0] acc_r;
  logic [RES_W-1:0] base;
  logic [SQ_W:0]    total;

  assign sq_nxt = SQ_W'(mag) * SQ_W'(mag);

  always_ff @(posedge clk) begin
    if (sq_load) begin
      sq_r <= sq_nxt;
    end
  end

  always_comb begin
    base  = first ? '0 : acc_r;
    total = {2'b00, base} + {1'b0, sq_r};
    if (!emit) begin
      acc_value = base;
    end else if (total[SQ_W:RES_W] != '0) begin
      acc_value = RES_MAX;
    end else begin
      acc_value = total[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (acc_step) begin
      acc_r <= acc_value;
    end
  end

endmodule

>>> hdl/jacobi_stencil_relax_unit.sv
// Top level of the Jacobi five-point relaxation unit: counters, pipeline control,
// config registers. Depends on jsr_pkg, jsr_line_buf, jsr_stencil, jsr_residual.
//
//   channel | ports                                          | direction
//   in      | in_valid, in_stall, in_cell_value              | cells in, raster order
//   out     | out_valid, out_stall, out_new_value..out_is_last | one request per interior cell
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | size register writes
//
// One cell per cycle while in_stall is low. The cell that completes a neighborhood passes
// these registers before its result is presented: the accepting edge loads the line-buffer
// read, then the stencil add, the multiplier and the accumulator stages add one register each.
// Synchronous reset clears control and the residual; the line buffers need no clearing
// pass. A stalled output holds its request and lets empty stages behind it fill before
// the input stalls.
module jacobi_stencil_relax_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [jsr_pkg::VAL_W-1:0] in_cell_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [jsr_pkg::VAL_W-1:0] out_new_value,
  output logic [jsr_pkg::ROW_W-1:0]     out_cell_row,
  output logic [jsr_pkg::COL_W-1:0]     out_cell_col,
  output logic [jsr_pkg::RES_W-1:0]     out_residual_sum,
  output logic                          out_is_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jsr_pkg::CFG_W-1:0]     cfg_data
);
  import jsr_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);

  logic [ROWS_CFG_W-1:0] grid_rows_r;
  logic [COLS_CFG_W-1:0] grid_cols_r;
  logic [ROW_W-1:0]      row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]         col_cnt_r, col_cnt_nxt;
  logic [ROWS_CFG_W-1:0] rows_eff;
  logic [15:0]           cols_wide;
  logic [CW:0]           cols_eff;
  logic [ROW_W-1:0]      r_eff;
  logic [CW-1:0]         c_eff;
  logic                  last_row, last_col;
  logic                  cfg_wr, in_acc;
  logic                  en0, en1, en2, en3;
  logic                  v1_r, v2_r, v3_r, out_valid_r;
  jsr_tag_t              tag0, tag1_r, tag2_r, tag3_r;
  logic [CW-1:0]         c1_r;
  logic [VAL_W-1:0]      cell1_r;
  logic [VAL_W-1:0]      mid_q, up_q, nv, mag;
  logic [VAL_W-1:0]      nv2_r, nv3_r, mag2_r;
  logic [RES_W-1:0]      acc_value;
  logic [VAL_W-1:0]      out_nv_r;
  logic [ROW_W-1:0]      out_row_r;
  logic [COL_W-1:0]      out_col_r;
  logic [RES_W-1:0]      out_res_r;
  logic                  out_last_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= ROWS_RESET;
      grid_cols_r <= COLS_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_GRID_ROWS:    grid_rows_r <= cfg_data[ROWS_CFG_W-1:0];
        REG_GRID_COLUMNS: grid_cols_r <= cfg_data[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes and locate the incoming cell
  always_comb begin
    if (grid_rows_r < ROWS_CFG_W'(MIN_SIZE)) begin
      rows_eff = ROWS_CFG_W'(MIN_SIZE);
    end else if (grid_rows_r > ROWS_CFG_W'(MAX_ROWS)) begin
      rows_eff = ROWS_CFG_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows_r;
    end
    if (grid_cols_r < COLS_CFG_W'(MIN_SIZE)) begin
      cols_wide = 16'(MIN_SIZE);
    end else if ({5'b0, grid_cols_r} > 16'(MAX_COLUMNS)) begin
      cols_wide = 16'(MAX_COLUMNS);
    end else begin
      cols_wide = {5'b0, grid_cols_r};
    end
    cols_eff = cols_wide[CW:0];
    if ({1'b0, row_cnt_r} >= rows_eff || {1'b0, col_cnt_r} >= cols_eff) begin
      r_eff = '0;
      c_eff = '0;
    end else begin
      r_eff = row_cnt_r;
      c_eff = col_cnt_r;
    end
    last_row   = ({1'b0, r_eff} == rows_eff - ROWS_CFG_W'(1));
    last_col   = ({1'b0, c_eff} == cols_eff - (CW+1)'(1));
    tag0.row   = r_eff - ROW_W'(1);
    tag0.col   = COL_W'(c_eff - CW'(1));
    tag0.emit  = (r_eff >= ROW_W'(2)) && (c_eff >= CW'(2));
    tag0.first = (r_eff == '0) && (c_eff == '0);
    tag0.last  = last_row && last_col;
    if (cfg_wr) begin
      row_cnt_nxt = '0;
      col_cnt_nxt = '0;
    end else if (!in_acc) begin
      row_cnt_nxt = row_cnt_r;
      col_cnt_nxt = col_cnt_r;
    end else if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = last_row ? '0 : r_eff + ROW_W'(1);
    end else begin
      col_cnt_nxt = c_eff + CW'(1);
      row_cnt_nxt = r_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // advance a stage when the one after it is empty or moving
  assign en3      = !out_valid_r || !out_stall;
  assign en2      = !v3_r || en3;
  assign en1      = !v2_r || en2;
  assign en0      = !v1_r || en1;
  assign in_stall = !en0;
  assign in_acc   = in_valid && en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en0) v1_r <= in_acc;
      if (en1) v2_r <= v1_r;
      if (en2) v3_r <= v2_r;
      if (en3) out_valid_r <= v3_r && tag3_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag1_r  <= tag0;
      c1_r    <= c_eff;
      cell1_r <= in_cell_value;
    end
    if (en1 && v1_r) begin
      tag2_r <= tag1_r;
      nv2_r  <= nv;
      mag2_r <= mag;
    end
    if (en2 && v2_r) begin
      tag3_r <= tag2_r;
      nv3_r  <= nv2_r;
    end
    if (en3 && v3_r && tag3_r.emit) begin
      out_nv_r   <= nv3_r;
      out_row_r  <= tag3_r.row;
      out_col_r  <= tag3_r.col;
      out_res_r  <= acc_value;
      out_last_r <= tag3_r.last;
    end
  end

  jsr_line_buf #(
    .DEPTH (MAX_COLUMNS)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_addr   (c_eff),
    .mid_wdata (in_cell_value),
    .up_wr_en  (en1 && v1_r),
    .up_waddr  (c1_r),
    .up_wdata  (mid_q),
    .mid_q     (mid_q),
    .up_q      (up_q)
  );

  jsr_stencil u_stencil (
    .clk       (clk),
    .adv       (en1 && v1_r),
    .cur_val   (cell1_r),
    .mid_q     (mid_q),
    .up_q      (up_q),
    .new_value (nv),
    .mag       (mag)
  );

  jsr_residual u_residual (
    .clk       (clk),
    .rst_n     (rst_n),
    .sq_load   (en2 && v2_r),
    .mag       (mag2_r),
    .acc_step  (en3 && v3_r),
    .first     (tag3_r.first),
    .emit      (tag3_r.emit),
    .acc_value (acc_value)
  );

  assign out_valid        = out_valid_r;
  assign out_new_value    = out_nv_r;
  assign out_cell_row     = out_row_r;
  assign out_cell_col     = out_col_r;
  assign out_residual_sum = out_res_r;
  assign out_is_last      = out_last_r;

endmodule

>>> tb/jsr_checker.sv
// Checker for the Jacobi five-point relaxation unit: watches the cell, size-write and
// result channels, predicts every relaxed cell and compares it field by field.
// Depends on jsr_pkg.
module jsr_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [jsr_pkg::VAL_W-1:0]       in_cell_value,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [jsr_pkg::VAL_W-1:0]       out_new_value,
  input  logic [jsr_pkg::ROW_W-1:0]       out_cell_row,
  input  logic [jsr_pkg::COL_W-1:0]       out_cell_col,
  input  logic [jsr_pkg::RES_W-1:0]       out_residual_sum,
  input  logic                            out_is_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [jsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jsr_pkg::CFG_W-1:0]       cfg_data,
  output int                              pending,
  output int                              mismatches
);
  import jsr_pkg::*;

  localparam logic [63:0] RESID_CAP = {1'b0, RES_MAX};

  typedef struct {
    logic [VAL_W-1:0] new_value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [RES_W-1:0] residual;
    logic             last;
  } relax_result_t;

  relax_result_t           relaxed_q[$];
  logic [ROWS_CFG_W-1:0]   rows_cfg;
  logic [COLS_CFG_W-1:0]   cols_cfg;
  logic [VAL_W-1:0]        prev_row_buf [MAX_COLUMNS];
  logic [VAL_W-1:0]        cur_row_buf [MAX_COLUMNS];
  logic [VAL_W-1:0]        mid_win [3];
  int unsigned             row_at;
  int unsigned             col_at;
  logic [63:0]             residual_acc;

  function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [63:0] widen(input logic [VAL_W-1:0] v);
    return {{(64 - VAL_W){v[VAL_W-1]}}, v};
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic relax_cell(input logic [VAL_W-1:0] cell_word);
    int unsigned        n_rows, n_cols, r, c;
    logic signed [63:0] around, relaxed, change;
    logic [63:0]        change_mag, change_sq;
    relax_result_t      res;
    n_rows = bounded(rows_cfg, MAX_ROWS);
    n_cols = bounded(cols_cfg, MAX_COLUMNS);
    r = row_at;
    c = col_at;
    if (r >= n_rows || c >= n_cols) begin
      r = 0;
      c = 0;
    end
    if (r == 0 && c == 0) residual_acc = '0;
    mid_win[0] = mid_win[1];
    mid_win[1] = mid_win[2];
    mid_win[2] = cur_row_buf[c];
    if (c >= 1) begin
      if (r >= 2 && c >= 2) begin
        around = widen(mid_win[0]) + widen(mid_win[2]) + widen(prev_row_buf[c-1])
               + widen(cur_row_buf[c-1]);
        relaxed = around >>> 2;
        change = relaxed - widen(mid_win[1]);
        change_mag = change[63] ? -change : change;
        change_sq = change_mag * change_mag;
        if (change_sq > RESID_CAP - residual_acc) residual_acc = RESID_CAP;
        else residual_acc = residual_acc + change_sq;
        res.new_value = relaxed[VAL_W-1:0];
        res.row = ROW_W'(r - 1);
        res.col = COL_W'(c - 1);
        res.residual = residual_acc[RES_W-1:0];
        res.last = (r == n_rows - 1) && (c == n_cols - 1);
        relaxed_q.push_back(res);
      end
      prev_row_buf[c-1] = mid_win[1];
    end
    if (c == n_cols - 1) prev_row_buf[c] = mid_win[2];
    cur_row_buf[c] = cell_word;
    if (c + 1 >= n_cols) begin
      col_at = 0;
      row_at = (r + 1 >= n_rows) ? 0 : r + 1;
    end else begin
      col_at = c + 1;
      row_at = r;
    end
  endtask

  always @(posedge clk) begin
    relax_result_t want;
    if (!rst_n) begin
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      row_at = 0;
      col_at = 0;
      residual_acc = '0;
      foreach (mid_win[i]) mid_win[i] = '0;
      relaxed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (relaxed_q.size() == 0) begin
          $error("result for row %0d col %0d with none expected", out_cell_row, out_cell_col);
          mismatches++;
        end else begin
          want = relaxed_q.pop_front();
          check_field("new_value", 64'(want.new_value), 64'(out_new_value));
          check_field("cell_row", 64'(want.row), 64'(out_cell_row));
          check_field("cell_col", 64'(want.col), 64'(out_cell_col));
          check_field("residual_sum", 64'(want.residual), 64'(out_residual_sum));
          check_field("is_last", 64'(want.last), 64'(out_is_last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_ROWS) rows_cfg = cfg_data[ROWS_CFG_W-1:0];
        else cols_cfg = cfg_data[COLS_CFG_W-1:0];
        row_at = 0;
        col_at = 0;
      end
      if (in_valid && !in_stall) relax_cell(in_cell_value);
    end
    pending = relaxed_q.size();
  end

endmodule

>>> tb/tb.sv
// Top of the Jacobi five-point relaxation unit testbench: drives cells, size writes and
// result stalls, and gives the verdict. Depends on jsr_pkg, jsr_checker and the unit.
module tb;
  import jsr_pkg::*;

  localparam int MAX_COLS     = MAX_COLUMNS;
  localparam int LIMIT        = 1000000;
  localparam int SETTLE       = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_CELLS = 1000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_cell_value;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_new_value;
  logic [ROW_W-1:0]        out_cell_row;
  logic [COL_W-1:0]        out_cell_col;
  logic [RES_W-1:0]        out_residual_sum;
  logic                    out_is_last;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  int                      pending;
  int                      mismatches;
  int                      cycles = 0;
  int                      eff_rows;
  int                      eff_cols;
  bit                      tx_calm = 1'b0;
  bit                      rx_calm = 1'b0;
  bit                      hold_req = 1'b0;
  bit                      hold_done = 1'b0;

  jacobi_stencil_relax_unit uut (.*);
  jsr_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL jacobi_stencil_relax_unit");
      $finish;
    end
  end

  function automatic int span(input int v, input int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] cell_pattern();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return 32'($urandom_range(0, 20'hF_FFFF)) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cell(input logic [VAL_W-1:0] v);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cell_value <= v;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
  endtask

  task automatic resize(input logic [CFG_W-1:0] rows_data, input logic [CFG_W-1:0] cols_data);
    write_reg(REG_GRID_ROWS, rows_data);
    write_reg(REG_GRID_COLUMNS, cols_data);
    cfg_valid <= 1'b0;
    eff_rows = span(rows_data, MAX_ROWS);
    eff_cols = span(cols_data[COLS_CFG_W-1:0], MAX_COLS);
  endtask

  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      n = rx_calm ? 0 : $urandom_range(0, 15);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        n = HOLD_CYCLES;
      end
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int               r, c, pick, reps, len, random_cells;
    bit               paused;
    logic [CFG_W-1:0] rows_data, cols_data;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cell_value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_ROWS;
    cfg_data = '0;
    paused = 1'b0;
    random_cells = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // partial grid at reset sizes, then restart by a size write
    repeat (4) send_cell($urandom);
    drain(SETTLE);
    resize(3, 3);
    // spike of opposite sign inside extreme neighbors: saturates the residual
    for (int i = 0; i < 9; i++)
      send_cell(i == 4 ? VAL_MIN : (i % 2) ? VAL_MAX : $urandom);
    drain(SETTLE);
    resize(2, 13'h1800);
    for (int i = 0; i < 9; i++)
      send_cell(i == 4 ? VAL_MAX : (i % 2) ? VAL_MIN : $urandom);

    // widest grid, sizes clamped from above and below, cut short
    drain(SETTLE);
    resize(0, 13'h1FFF);
    repeat (45) send_cell(cell_pattern());

    // tallest grid, cut short
    drain(SETTLE);
    resize(13'h1FFF, 3);
    repeat (45) send_cell(cell_pattern());

    // long result hold-off while cells keep coming
    drain(SETTLE);
    resize(16, 16);
    hold_req = 1'b1;
    tx_calm = 1'b1;
    repeat (eff_rows * eff_cols) send_cell(cell_pattern());
    tx_calm = 1'b0;

    while (random_cells < RANDOM_CELLS) begin
      drain(SETTLE);
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      rows_data = CFG_W'(r);
      cols_data = {2'($urandom_range(0, 3)), COLS_CFG_W'(c)};
      pick = $urandom_range(0, 5);
      if (pick != 1) eff_rows = span(r, MAX_ROWS);
      if (pick != 0) eff_cols = span(c, MAX_COLS);
      case (pick)
        0: write_reg(REG_GRID_ROWS, rows_data);
        1: write_reg(REG_GRID_COLUMNS, cols_data);
        2: begin
          write_reg(REG_GRID_COLUMNS, cols_data);
          write_reg(REG_GRID_ROWS, rows_data);
        end
        default: begin
          write_reg(REG_GRID_ROWS, rows_data);
          write_reg(REG_GRID_COLUMNS, cols_data);
        end
      endcase
      cfg_valid <= 1'b0;
      tx_calm = ($urandom_range(0, 3) == 0);
      reps = $urandom_range(1, 3);
      repeat (reps) begin
        len = eff_rows * eff_cols;
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len - 1);
        for (int i = 0; i < len; i++) begin
          // once in the run, with more than one result pending, hold the sender until every pending result is out
          if (!paused && pending > 1) begin
            drain(1);
            paused = 1'b1;
          end
          send_cell(cell_pattern());
          random_cells++;
        end
      end
    end

    drain(2 * SETTLE);
    if (mismatches == 0) $display("PASS jacobi_stencil_relax_unit");
    else $display("FAIL jacobi_stencil_relax_unit");
    $finish;
  end

endmodule
